[rtl/core/btfc_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package btfc_pkg;

	localparam int HEADER_BYTES    = 6;
	localparam int MAX_FRAME_BYTES = 23;
	localparam int STORE_DEPTH     = 8;
	localparam int POS_W           = 5;
	localparam int QUEUE_DEPTH_DEF = 2;

	localparam logic [7:0] CHECK_SEED = 8'hFF;

	typedef logic [POS_W-1:0] pos_t;
	typedef logic [STORE_DEPTH-1:0][7:0] hdr_bytes_t;

	// one finished telegram: header bytes 0..7 and checksum verdict
	typedef struct packed {
		logic       check_ok;
		hdr_bytes_t hdr;
	} frame_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

endpackage

`default_nettype wire

[rtl/core/btfc_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module btfc_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [7:0]         rx_byte,
	input  wire logic               frame_start,
	input  wire btfc_pkg::q_status_t q_status,
	output logic                    push,
	output btfc_pkg::frame_rec_t    push_rec
);
	import btfc_pkg::*;

	pos_t       pos_q;
	logic [7:0] chk_q;
	hdr_bytes_t hdr_q;

	logic       accept;
	logic       restart;
	pos_t       pos;
	logic [7:0] chk;
	hdr_bytes_t hdr_cur;
	pos_t       plen;
	logic       hit;

	assign in_stall = q_status.full;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		restart = frame_start || ({1'b0, pos_q} >= (POS_W+1)'(MAX_FRAME_BYTES));
		pos     = restart ? '0 : pos_q;
		chk     = restart ? CHECK_SEED : chk_q;
		for (int i = 0; i < STORE_DEPTH; i++) begin
			hdr_cur[i] = (pos == POS_W'(i)) ? rx_byte : hdr_q[i];
		end
		plen = {1'b0, hdr_cur[5][3:0]} + 1'b1;
		// check byte sits right after header plus payload
		hit  = (pos > POS_W'(HEADER_BYTES - 1)) && (pos == POS_W'(HEADER_BYTES) + plen);
	end

	assign push              = accept && hit;
	assign push_rec.check_ok = (chk == rx_byte);
	assign push_rec.hdr      = hdr_cur;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
			chk_q <= CHECK_SEED;
			hdr_q <= '0;
		end else if (accept) begin
			hdr_q <= hdr_cur;
			if (hit) begin
				pos_q <= '0;
				chk_q <= CHECK_SEED;
			end else begin
				pos_q <= pos + 1'b1;
				chk_q <= chk ^ rx_byte;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/btfc_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module btfc_queue #(
	parameter int DEPTH = btfc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire btfc_pkg::frame_rec_t push_rec,
	input  wire logic                 pop,
	output btfc_pkg::frame_rec_t      pop_rec,
	output btfc_pkg::q_status_t       status
);
	import btfc_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	frame_rec_t       mem [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign status.full  = (cnt_q == CNT_W'(DEPTH));
	assign status.empty = (cnt_q == '0);
	assign pop_rec      = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_rec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

[rtl/core/btfc_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module btfc_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire btfc_pkg::q_status_t  q_status,
	input  wire btfc_pkg::frame_rec_t pop_rec,
	output logic                      pop,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      check_ok,
	output logic                      repeated,
	output logic [1:0]                priority_res,
	output logic [15:0]               source_address,
	output logic [15:0]               target_address,
	output logic                      target_is_group,
	output logic [2:0]                hop_count,
	output logic [4:0]                payload_length,
	output logic [3:0]                command,
	output logic [1:0]                communication_kind,
	output logic [3:0]                sequence_number,
	output logic [5:0]                first_data
);
	import btfc_pkg::*;

	logic       valid_q;
	hdr_bytes_t h;

	assign h         = pop_rec.hdr;
	assign out_valid = valid_q;
	// refill the output register when empty or when its transfer completes
	assign pop       = !q_status.empty && (!valid_q || !out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			check_ok           <= pop_rec.check_ok;
			repeated           <= ~h[0][5];
			priority_res       <= h[0][3:2];
			source_address     <= {h[1], h[2]};
			target_address     <= {h[3], h[4]};
			target_is_group    <= h[5][7];
			hop_count          <= h[5][6:4];
			payload_length     <= {1'b0, h[5][3:0]} + 1'b1;
			command            <= {h[6][1:0], h[7][7:6]};
			communication_kind <= h[6][7:6];
			sequence_number    <= h[6][5:2];
			first_data         <= h[7][5:0];
		end
	end

endmodule

`default_nettype wire

[rtl/core/bus_telegram_frame_checker.sv]
// Telegram checker: takes one bus byte per transfer, one per clock when
// unstalled. Bytes 0..7 of a telegram are held as header; the check byte is
// found at position 6 + (byte 5 low nibble + 1) and compared with a running
// XOR seeded 0xFF. frame_start forces the current byte to byte 0 and drops
// any partial telegram silently. The front end never stalls for a byte that
// ends no telegram unless the result queue is full; each finished telegram
// enters a QUEUE_DEPTH-deep result queue and is decoded into the output
// register once that register is empty or its result is being taken.
// in_stall rises only when QUEUE_DEPTH results wait behind a stalled output.
`timescale 1ns / 1ps
`default_nettype none

module bus_telegram_frame_checker #(
	parameter int QUEUE_DEPTH = btfc_pkg::QUEUE_DEPTH_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  rx_byte,
	input  wire logic        frame_start,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             check_ok,
	output logic             repeated,
	output logic [1:0]       priority_res,
	output logic [15:0]      source_address,
	output logic [15:0]      target_address,
	output logic             target_is_group,
	output logic [2:0]       hop_count,
	output logic [4:0]       payload_length,
	output logic [3:0]       command,
	output logic [1:0]       communication_kind,
	output logic [3:0]       sequence_number,
	output logic [5:0]       first_data
);
	import btfc_pkg::*;

	q_status_t  q_status;
	logic       push;
	logic       pop;
	frame_rec_t push_rec;
	frame_rec_t pop_rec;

	btfc_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.rx_byte    (rx_byte),
		.frame_start(frame_start),
		.q_status   (q_status),
		.push       (push),
		.push_rec   (push_rec)
	);

	btfc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_rec(push_rec),
		.pop     (pop),
		.pop_rec (pop_rec),
		.status  (q_status)
	);

	btfc_back u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_status          (q_status),
		.pop_rec           (pop_rec),
		.pop               (pop),
		.out_valid         (out_valid),
		.out_stall         (out_stall),
		.check_ok          (check_ok),
		.repeated          (repeated),
		.priority_res      (priority_res),
		.source_address    (source_address),
		.target_address    (target_address),
		.target_is_group   (target_is_group),
		.hop_count         (hop_count),
		.payload_length    (payload_length),
		.command           (command),
		.communication_kind(communication_kind),
		.sequence_number   (sequence_number),
		.first_data        (first_data)
	);

endmodule

`default_nettype wire

[rtl/core/btfc_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

module btfc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_stall,
	input wire logic [7:0]  rx_byte,
	input wire logic        frame_start,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic        check_ok,
	input wire logic        repeated,
	input wire logic [1:0]  priority_res,
	input wire logic [15:0] source_address,
	input wire logic [15:0] target_address,
	input wire logic        target_is_group,
	input wire logic [2:0]  hop_count,
	input wire logic [4:0]  payload_length,
	input wire logic [3:0]  command,
	input wire logic [1:0]  communication_kind,
	input wire logic [3:0]  sequence_number,
	input wire logic [5:0]  first_data
);

	// stalled byte transfer keeps its payload
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(rx_byte) && $stable(frame_start))
		else $error("input changed while stalled");

	// held result keeps its fields while stalled
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(source_address)
			&& $stable(target_address) && $stable(check_ok) && $stable(command)
			&& $stable(repeated) && $stable(priority_res) && $stable(target_is_group)
			&& $stable(hop_count) && $stable(payload_length)
			&& $stable(communication_kind) && $stable(sequence_number)
			&& $stable(first_data))
		else $error("result changed while stalled");

	// input only backs up when results are piled up behind the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled with no result pending");

	// a fresh result is preceded by a byte transfer, via the queue and output register
	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result appeared without a byte transfer");

	a_len_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (payload_length != 5'd0) && (payload_length <= 5'd16))
		else $error("payload length out of range");

endmodule

bind bus_telegram_frame_checker btfc_checker u_btfc_checker (.*);

`default_nettype wire

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;
	import btfc_pkg::*;

	localparam int QUIET_LIMIT  = 2000;
	localparam int RANDOM_BYTES = 450;

	typedef struct {
		logic [7:0] data;
		logic       start;
	} bus_byte_t;

	typedef struct {
		logic        check_ok;
		logic        repeated;
		logic [1:0]  prio;
		logic [15:0] src;
		logic [15:0] dst;
		logic        grp;
		logic [2:0]  hops;
		logic [4:0]  plen;
		logic [3:0]  cmd;
		logic [1:0]  kind;
		logic [3:0]  seq;
		logic [5:0]  data;
	} telegram_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  rx_byte = 8'h00;
	logic        frame_start = 1'b0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        check_ok;
	logic        repeated;
	logic [1:0]  priority_res;
	logic [15:0] source_address;
	logic [15:0] target_address;
	logic        target_is_group;
	logic [2:0]  hop_count;
	logic [4:0]  payload_length;
	logic [3:0]  command;
	logic [1:0]  communication_kind;
	logic [3:0]  sequence_number;
	logic [5:0]  first_data;

	bus_byte_t  bus_q[$];
	telegram_t  telegram_q[$];

	// predictor state
	pos_t        tel_pos = '0;
	logic [7:0]  tel_xor = CHECK_SEED;
	logic [7:0]  tel_hdr[STORE_DEPTH];

	int n_total = 1;
	int n_in = 0;
	int n_frames = 0;
	int n_bad_check = 0;
	int n_errors = 0;
	int quiet = 0;

	bus_telegram_frame_checker u_top (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.rx_byte            (rx_byte),
		.frame_start        (frame_start),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.check_ok           (check_ok),
		.repeated           (repeated),
		.priority_res       (priority_res),
		.source_address     (source_address),
		.target_address     (target_address),
		.target_is_group    (target_is_group),
		.hop_count          (hop_count),
		.payload_length     (payload_length),
		.command            (command),
		.communication_kind (communication_kind),
		.sequence_number    (sequence_number),
		.first_data         (first_data)
	);

	always #5 clk = ~clk;

	function automatic int phase_now();
		int ph;
		ph = (n_in * 3) / n_total;
		return (ph > 2) ? 2 : ph;
	endfunction

	function automatic int send_idle_pct();
		case (phase_now())
			0: return 7;
			1: return 50;
			default: return 0;
		endcase
	endfunction

	function automatic int recv_idle_pct();
		case (phase_now())
			0: return 50;
			1: return 7;
			default: return 0;
		endcase
	endfunction

	// one accepted bus byte: update header/xor, queue a decoded telegram on the check byte
	function automatic void telegram_accept(logic [7:0] b, logic start);
		int p;
		int plen;
		telegram_t t;
		if (start || tel_pos >= MAX_FRAME_BYTES) begin
			tel_pos = '0;
			tel_xor = CHECK_SEED;
		end
		p = tel_pos;
		if (p < STORE_DEPTH)
			tel_hdr[p] = b;
		plen = tel_hdr[5][3:0] + 1;
		if (p > 5 && p == HEADER_BYTES + plen) begin
			t.check_ok = (tel_xor == b);
			t.repeated = ~tel_hdr[0][5];
			t.prio     = tel_hdr[0][3:2];
			t.src      = {tel_hdr[1], tel_hdr[2]};
			t.dst      = {tel_hdr[3], tel_hdr[4]};
			t.grp      = tel_hdr[5][7];
			t.hops     = tel_hdr[5][6:4];
			t.plen     = plen[4:0];
			t.cmd      = {tel_hdr[6][1:0], tel_hdr[7][7:6]};
			t.kind     = tel_hdr[6][7:6];
			t.seq      = tel_hdr[6][5:2];
			t.data     = tel_hdr[7][5:0];
			telegram_q.push_back(t);
			tel_pos = '0;
			tel_xor = CHECK_SEED;
		end else begin
			tel_xor = tel_xor ^ b;
			tel_pos = pos_t'(p + 1);
		end
	endfunction

	task automatic add_frame(input logic [7:0] fill, input bit rand_fill, input int plen,
			input bit good, input bit start);
		logic [7:0] x;
		logic [7:0] b;
		x = CHECK_SEED;
		for (int i = 0; i < HEADER_BYTES + plen; i++) begin
			b = rand_fill ? 8'($urandom) : fill;
			if (i == 5)
				b[3:0] = 4'(plen - 1);
			bus_q.push_back('{data: b, start: (i == 0) ? start : 1'b0});
			x = x ^ b;
		end
		if (!good)
			x = x ^ 8'($urandom_range(255, 1));
		bus_q.push_back('{data: x, start: 1'b0});
	endtask

	task automatic add_bytes(input int n, input bit first_start, input int start_pct);
		for (int i = 0; i < n; i++)
			bus_q.push_back('{data: 8'($urandom),
				start: (i == 0 && first_start) || ($urandom_range(99) < start_pct)});
	endtask

	task automatic check_field(input string name, input int unsigned exp,
			input int unsigned act);
		if (exp != act) begin
			$error("%s: expected %0h, got %0h", name, exp, act);
			n_errors++;
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		bus_byte_t nb;
		if (!arst_n) begin
			in_valid <= 1'b0;
			rx_byte <= 8'h00;
			frame_start <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				telegram_accept(rx_byte, frame_start);
				n_in++;
			end
			if (!in_valid || !in_stall) begin
				if (bus_q.size() > 0 && $urandom_range(99) >= send_idle_pct()) begin
					nb = bus_q.pop_front();
					in_valid <= 1'b1;
					rx_byte <= nb.data;
					frame_start <= nb.start;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		telegram_t e;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (telegram_q.size() == 0) begin
					$error("telegram result with none pending");
					n_errors++;
				end else begin
					e = telegram_q.pop_front();
					n_frames++;
					if (!check_ok)
						n_bad_check++;
					check_field("check_ok", e.check_ok, check_ok);
					check_field("repeated", e.repeated, repeated);
					check_field("priority_res", e.prio, priority_res);
					check_field("source_address", e.src, source_address);
					check_field("target_address", e.dst, target_address);
					check_field("target_is_group", e.grp, target_is_group);
					check_field("hop_count", e.hops, hop_count);
					check_field("payload_length", e.plen, payload_length);
					check_field("command", e.cmd, command);
					check_field("communication_kind", e.kind, communication_kind);
					check_field("sequence_number", e.seq, sequence_number);
					check_field("first_data", e.data, first_data);
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct());
		end
	end

	// watchdog: too long without any transfer on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet = 0;
			else
				quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
				$display("tb NOT OK");
				$finish;
			end
		end
	end

	initial begin
		int n_directed;
		int sel;
		bit in_sync;
		bit first;
		for (int i = 0; i < STORE_DEPTH; i++)
			tel_hdr[i] = 8'h00;

		// shortest payload, all-ones header but for the length nibble; check byte doubles as byte 7
		add_frame(8'hFF, 1'b0, 1, 1'b1, 1'b1);
		// partial telegram dropped by resync, then all-zero frame with bad check
		add_bytes(3, 1'b1, 0);
		add_frame(8'h00, 1'b0, 1, 1'b0, 1'b1);
		n_directed = bus_q.size();

		in_sync = 1'b1;
		first = 1'b1;
		while (bus_q.size() < n_directed + RANDOM_BYTES) begin
			sel = $urandom_range(99);
			if (first || sel < 80) begin
				add_frame(8'h00, 1'b1, first ? 16 : $urandom_range(16, 1),
					$urandom_range(9) != 0, in_sync ? 1'($urandom_range(1)) : 1'b1);
				in_sync = 1'b1;
				first = 1'b0;
			end else if (sel < 92) begin
				add_bytes($urandom_range(12, 1), 1'b1, 0);
				in_sync = 1'b0;
			end else begin
				add_bytes($urandom_range(4, 1), 1'b0, 30);
				in_sync = 1'b0;
			end
		end
		n_total = bus_q.size();

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		while (bus_q.size() > 0 || in_valid || telegram_q.size() > 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("%0d bus bytes sent, %0d telegrams decoded (%0d with failed checksum)",
			n_in, n_frames, n_bad_check);
		$display("covered short/long payloads, resync mid-telegram, noise and stalls");
		if (n_errors == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

endmodule
